### rtl/cfp_pkg.sv
// Shared types and constants for the command frame parser.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

   // byte and register widths
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CMD_W     = 32;
   localparam int unsigned PAYLOAD_N = 8;
   localparam int unsigned CNT_W     = $clog2(PAYLOAD_N);

   // register indexes and reset values
   localparam int unsigned CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE = 1'd1;
   localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hFA;
   localparam logic [BYTE_W-1:0] IGNORE_RESET = 8'hFF;

   // request queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // response packing
   localparam int unsigned RSP_FIELDS_W = 2 * CMD_W + 1;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // front state machine
   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_PAYLOAD,
      FRONT_CHECK
   } front_state_type;

   // what the back has to do with a queued byte
   typedef enum logic [1:0] {
      OP_OPEN,
      OP_DATA,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
   } entry_type;

endpackage : cfp_pkg

`default_nettype wire

### rtl/cfp_front.sv
// Front end: holds the sync and ignore registers, drops ignore bytes and
// classifies each remaining byte by frame position. Depends on cfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfp_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [cfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfp_pkg::BYTE_W-1:0]    csr_wdata,
   input  wire logic                          byte_valid,
   input  wire logic [cfp_pkg::BYTE_W-1:0]    byte_data,
   input  wire logic                          queue_full,
   output logic                               byte_ready,
   output logic                               push,
   output cfp_pkg::entry_type                 push_entry
);
   import cfp_pkg::*;

   logic [BYTE_W-1:0] sync_ff, sync_in;
   logic [BYTE_W-1:0] ignore_ff, ignore_in;
   front_state_type   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              take;

   // configuration registers
   always_comb begin
      sync_in   = sync_ff;
      ignore_in = ignore_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SYNC:   sync_in   = csr_wdata;
            CSR_IGNORE: ignore_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= SYNC_RESET;
         ignore_ff <= IGNORE_RESET;
         state_ff  <= FRONT_IDLE;
         count_ff  <= '0;
      end else begin
         sync_ff   <= sync_in;
         ignore_ff <= ignore_in;
         state_ff  <= state_in;
         count_ff  <= count_in;
      end
   end

   assign byte_ready = !queue_full;
   assign take       = byte_valid && !queue_full && (byte_data != ignore_ff);

   // frame position tracking and classification
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      push            = 1'b0;
      push_entry.op   = OP_DATA;
      push_entry.data = byte_data;
      if (take) begin
         case (state_ff)
            FRONT_IDLE: begin
               if (byte_data == sync_ff) begin
                  push          = 1'b1;
                  push_entry.op = OP_OPEN;
                  state_in      = FRONT_PAYLOAD;
                  count_in      = '0;
               end
            end
            FRONT_PAYLOAD: begin
               push          = 1'b1;
               push_entry.op = OP_DATA;
               count_in      = count_ff + 1'b1;
               if (count_ff == CNT_W'(PAYLOAD_N - 1)) begin
                  state_in = FRONT_CHECK;
               end
            end
            FRONT_CHECK: begin
               push          = 1'b1;
               push_entry.op = OP_CHECK;
               state_in      = FRONT_IDLE;
            end
            default: begin
               state_in = FRONT_IDLE;
            end
         endcase
      end
   end

endmodule : cfp_front

`default_nettype wire

### rtl/cfp_queue.sv
// Short request queue between front and back so either side may stall.
// Depends on cfp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cfp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cfp_pkg::entry_type push_entry,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output cfp_pkg::entry_type      head
);
   import cfp_pkg::*;

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // fill level never passes the depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill level above depth");

   // fill level tracks the pointer distance
   a_ptr_match : assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with fill level");

   // a push into a full queue would lose a request
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule : cfp_queue

`default_nettype wire

### rtl/cfp_back.sv
// Back end: collects payload, keeps the running sum and held commands and
// drives the response register. Depends on cfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfp_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        empty,
   input  wire cfp_pkg::entry_type          head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [cfp_pkg::RSP_DATA_W-1:0]   rsp_data
);
   import cfp_pkg::*;

   logic [2*CMD_W-1:0] payload_ff, payload_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [CMD_W-1:0]   linear_ff, linear_in;
   logic [CMD_W-1:0]   angular_ff, angular_in;
   logic               ok_ff, ok_in;
   logic               valid_ff, valid_in;
   logic               out_free;

   assign out_free = !valid_ff || rsp_ready;
   // only a checksum needs the response register
   assign pop = !empty && ((head.op != OP_CHECK) || out_free);

   // carry out the queued request
   always_comb begin
      payload_in = payload_ff;
      sum_in     = sum_ff;
      linear_in  = linear_ff;
      angular_in = angular_ff;
      ok_in      = ok_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (pop) begin
         case (head.op)
            OP_OPEN: begin
               sum_in = '0;
            end
            OP_DATA: begin
               payload_in = {head.data, payload_ff[2*CMD_W-1:BYTE_W]};
               sum_in     = sum_ff + head.data;
            end
            OP_CHECK: begin
               ok_in    = (sum_ff == head.data);
               valid_in = 1'b1;
               if (sum_ff == head.data) begin
                  linear_in  = payload_ff[CMD_W-1:0];
                  angular_in = payload_ff[2*CMD_W-1:CMD_W];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff <= '0;
         sum_ff     <= '0;
         linear_ff  <= '0;
         angular_ff <= '0;
         ok_ff      <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         payload_ff <= payload_in;
         sum_ff     <= sum_in;
         linear_ff  <= linear_in;
         angular_ff <= angular_in;
         ok_ff      <= ok_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), ok_ff, angular_ff, linear_ff};

   // a checksum request always yields a response next cycle
   a_check_resp : assert property (@(posedge clock) disable iff (reset)
      (pop && head.op == OP_CHECK) |=> valid_ff)
      else $error("checksum popped without response");

   // held commands only move when a response is loaded
   a_held_stable : assert property (@(posedge clock) disable iff (reset)
      !(pop && head.op == OP_CHECK) |=> ($stable(linear_ff) && $stable(angular_ff)))
      else $error("held command changed outside a checksum");

   // a stalled response is not overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !(pop && head.op == OP_CHECK))
      else $error("response overwritten while stalled");

endmodule : cfp_back

`default_nettype wire

### rtl/command_frame_parser.sv
// Command frame parser: turns a received byte stream into velocity commands.
// Bytes enter on the req_ channel, one byte per request in req_tdata[7:0].
// Bytes equal to the ignore register are dropped anywhere. In idle, a byte
// equal to the sync register opens a frame; eight payload bytes follow
// (linear word then angular word, little-endian) and then a checksum byte.
// Each checksum byte gives one rsp_ request with the held commands and an
// ok flag; the commands are replaced only when the payload sum matches.
// Throughput: one byte per cycle while the queue is not full; the front tags
// bytes into a 4-entry queue and the back consumes one queued byte per cycle
// unless a checksum waits for the response register. With nothing ahead of it
// in the queue, a checksum byte passes a queue entry, then the response register.
// When rsp_tready is low, payload bytes keep flowing until a checksum reaches the
// queue head; it waits until the response register frees, and req_tready drops
// once the queue holds four entries. Reset clears the frame state, the queue and
// the held commands, and loads sync 0xFA and ignore 0xFF. The user must write csr_
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration writes
   input  wire logic                          csr_we,
   input  wire logic [cfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfp_pkg::BYTE_W-1:0]    csr_wdata,
   // received bytes
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [cfp_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   // frame results
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [31:0] linear_cmd_bits, [63:32] angular_cmd_bits, [64] frame_ok
   output logic [cfp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import cfp_pkg::*;

   logic      push, pop, full, empty;
   entry_type push_entry, head;

   // tag bytes by frame position
   cfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .queue_full (full),
      .byte_ready (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple front and back
   cfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   // payload collection, checksum and response
   cfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule : command_frame_parser

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for command_frame_parser: byte stream in, frame results out.
// Depends on rtl/cfp_pkg.sv and rtl/command_frame_parser.sv; it reads no files.
`timescale 1ns / 1ps

module tb_top;
   import cfp_pkg::*;

   // parser phase codes
   localparam logic [3:0] PHASE_IDLE  = 4'd0;
   localparam logic [3:0] PHASE_FIRST = 4'd1;
   localparam logic [3:0] PHASE_LAST  = 4'd8;
   localparam logic [3:0] PHASE_CHECK = 4'd9;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_CYCLES  = 300;
   localparam int MAX_PRINTED   = 40;

   typedef struct packed {
      logic [CMD_W-1:0] linear;
      logic [CMD_W-1:0] angular;
      logic             ok;
   } frame_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              typed;
      frame_result_type  want;
   } stim_row_type;

   localparam frame_result_type NO_FRAME = '0;
   localparam int DIRECTED_N = 23;

   // directed bytes under reset settings (sync 0xFA, ignore 0xFF)
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{8'h00, 1'b0, NO_FRAME},   // idle noise
      '{8'hFF, 1'b0, NO_FRAME},   // ignore byte while idle
      '{8'hFA, 1'b0, NO_FRAME},   // sync opens a frame
      '{8'h01, 1'b0, NO_FRAME},
      '{8'h02, 1'b0, NO_FRAME},
      '{8'h03, 1'b0, NO_FRAME},
      '{8'h04, 1'b0, NO_FRAME},
      '{8'h05, 1'b0, NO_FRAME},
      '{8'h06, 1'b0, NO_FRAME},
      '{8'h07, 1'b0, NO_FRAME},
      '{8'h08, 1'b0, NO_FRAME},
      // bad checksum: held commands still at reset, flag low
      '{8'h00, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
      '{8'hFA, 1'b0, NO_FRAME},
      '{8'hFE, 1'b0, NO_FRAME},
      '{8'hFA, 1'b0, NO_FRAME},   // sync inside a frame is payload
      '{8'hFF, 1'b0, NO_FRAME},   // ignore byte inside a frame
      '{8'h80, 1'b0, NO_FRAME},
      '{8'h7F, 1'b0, NO_FRAME},
      '{8'h00, 1'b0, NO_FRAME},
      '{8'h01, 1'b0, NO_FRAME},
      '{8'hFE, 1'b0, NO_FRAME},
      '{8'h00, 1'b0, NO_FRAME},
      // good checksum, wrapping sum of the payload
      '{8'hF6, 1'b1, '{32'h7F80_FAFE, 32'h00FE_0100, 1'b1}}
   };

   // random phases: register settings, byte budget and idling
   localparam int PHASES_N = 6;
   localparam int PHASE_BYTES [PHASES_N]  = '{250, 220, 220, 60, 260, 240};
   localparam int PHASE_SEND_IDLE [PHASES_N] = '{13, 13, 48, 48, 0, 0};
   localparam int PHASE_RECV_IDLE [PHASES_N] = '{48, 48, 13, 13, 0, 0};

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [BYTE_W-1:0]     csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;    // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [31:0] linear_cmd_bits, [63:32] angular_cmd_bits, [64] frame_ok
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor state
   logic [BYTE_W-1:0]    cfg_sync;
   logic [BYTE_W-1:0]    cfg_ignore;
   logic [3:0]           frame_phase;
   logic [63:0]          payload_bytes;
   logic [BYTE_W-1:0]    payload_sum;
   logic [CMD_W-1:0]     held_linear;
   logic [CMD_W-1:0]     held_angular;

   frame_result_type pending_frames [$];
   int  mismatch_count;
   int  bytes_sent;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_left;
   bit  stall_request;

   command_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   // one received byte through the parser; returns 1 when a frame completes
   function automatic bit parse_byte(input logic [BYTE_W-1:0] rx,
                                     output frame_result_type res);
      logic ok;
      res = NO_FRAME;
      if (rx == cfg_ignore) return 1'b0;
      if (frame_phase inside {[PHASE_FIRST:PHASE_LAST]}) begin
         payload_bytes[(frame_phase - PHASE_FIRST) * 8 +: 8] = rx;
         payload_sum = payload_sum + rx;
         frame_phase = frame_phase + 4'd1;
         return 1'b0;
      end
      if (frame_phase == PHASE_CHECK) begin
         ok = (payload_sum == rx);
         if (ok) begin
            held_linear  = payload_bytes[31:0];
            held_angular = payload_bytes[63:32];
         end
         frame_phase = PHASE_IDLE;
         res = '{held_linear, held_angular, ok};
         return 1'b1;
      end
      // idle or an unused phase code
      if (rx == cfg_sync) begin
         frame_phase   = PHASE_FIRST;
         payload_bytes = '0;
         payload_sum   = '0;
      end else begin
         frame_phase = PHASE_IDLE;
      end
      return 1'b0;
   endfunction

   // offer one byte, wait for acceptance, then predict
   task automatic push_byte(input logic [BYTE_W-1:0] rx, input bit typed,
                            input frame_result_type want);
      frame_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (rx != cfg_ignore) bytes_sent++;
      if (parse_byte(rx, predicted)) pending_frames.push_back(typed ? want : predicted);
   endtask

   function automatic logic [BYTE_W-1:0] pick_data_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(255));
      while (b == cfg_ignore) b = BYTE_W'($urandom_range(255));
      return b;
   endfunction

   // wait for every frame result, then let the queue drain
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [BYTE_W-1:0] sync_b,
                                  input logic [BYTE_W-1:0] ignore_b);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC;
      csr_wdata <= sync_b;
      @(posedge clock);
      csr_index <= CSR_IGNORE;
      csr_wdata <= ignore_b;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_sync   = sync_b;
      cfg_ignore = ignore_b;
   endtask

   // mostly well-formed frames, with noise, stray ignore bytes and truncation
   task automatic run_random(input int budget, input bit with_stall);
      int start_count;
      int pick;
      int n;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sum;
      bit stall_issued;
      start_count  = bytes_sent;
      stall_issued = 1'b0;
      while (bytes_sent - start_count < budget) begin
         if (with_stall && !stall_issued && bytes_sent - start_count >= 100) begin
            stall_request = 1'b1;
            stall_issued  = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 75) begin
            push_byte(cfg_sync, 1'b0, NO_FRAME);
            sum = '0;
            for (int k = 0; k < 8; k++) begin
               if ($urandom_range(9) == 0) push_byte(cfg_ignore, 1'b0, NO_FRAME);
               b = pick_data_byte();
               sum = sum + b;
               push_byte(b, 1'b0, NO_FRAME);
            end
            if ($urandom_range(3) == 0) push_byte(BYTE_W'($urandom_range(255)), 1'b0, NO_FRAME);
            else push_byte(sum, 1'b0, NO_FRAME);
         end else if (pick < 90) begin
            n = $urandom_range(4, 1);
            repeat (n) push_byte(BYTE_W'($urandom_range(255)), 1'b0, NO_FRAME);
         end else begin
            push_byte(cfg_sync, 1'b0, NO_FRAME);
            n = $urandom_range(7);
            repeat (n) push_byte(pick_data_byte(), 1'b0, NO_FRAME);
         end
      end
   endtask

   // frame result checking and receiver back-pressure
   initial begin
      frame_result_type want;
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               flag_mismatch($sformatf("unexpected frame result %h", rsp_tdata));
            end else begin
               want = pending_frames.pop_front();
               if (rsp_tdata[31:0] !== want.linear)
                  flag_mismatch($sformatf("linear %h, wanted %h", rsp_tdata[31:0], want.linear));
               if (rsp_tdata[63:32] !== want.angular)
                  flag_mismatch($sformatf("angular %h, wanted %h", rsp_tdata[63:32],
                                          want.angular));
               if (rsp_tdata[64] !== want.ok)
                  flag_mismatch($sformatf("frame_ok %b, wanted %b", rsp_tdata[64], want.ok));
            end
         end
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = STALL_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // stimulus sequence
   initial begin
      logic [BYTE_W-1:0] s;
      logic [BYTE_W-1:0] i;
      int drain;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      mismatch_count = 0;
      bytes_sent     = 0;
      stall_request  = 1'b0;
      send_idle_pct  = PHASE_SEND_IDLE[0];
      recv_idle_pct  = PHASE_RECV_IDLE[0];
      cfg_sync       = SYNC_RESET;
      cfg_ignore     = IGNORE_RESET;
      frame_phase    = PHASE_IDLE;
      payload_bytes  = '0;
      payload_sum    = '0;
      held_linear    = '0;
      held_angular   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_N; r++)
         push_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

      // random phases over several register settings
      for (int p = 0; p < PHASES_N; p++) begin
         wait_quiet();
         case (p)
            0: begin s = SYNC_RESET; i = IGNORE_RESET; end
            1: begin s = 8'h00; i = 8'hFF; end
            2: begin s = 8'hFF; i = 8'h00; end
            3: begin s = 8'h5A; i = 8'h5A; end   // sync equal to ignore: no frame opens
            4: begin
               s = BYTE_W'($urandom_range(255));
               i = BYTE_W'($urandom_range(255));
               while (i == s) i = BYTE_W'($urandom_range(255));
            end
            default: begin s = BYTE_W'($urandom_range(255)); i = ~s; end
         endcase
         write_registers(s, i);
         send_idle_pct = PHASE_SEND_IDLE[p];
         recv_idle_pct = PHASE_RECV_IDLE[p];
         run_random(PHASE_BYTES[p], p == 0);
      end

      // drain
      req_tvalid <= 1'b0;
      drain = 0;
      while (pending_frames.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_frames.size() != 0)
         flag_mismatch($sformatf("%0d frame results never arrived", pending_frames.size()));

      if (mismatch_count == 0) begin
         $display("command_frame_parser test passed");
      end else begin
         $display("command_frame_parser test failed");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("command_frame_parser test failed");
      $finish;
   end

endmodule
